FILE: hw/rtl/csc_pkg.sv
package csc_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int UNIT_FRAC  = 14;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = UNIT_FRAC + 1;

	localparam logic [30:0] RADIUS_RESET = 31'(1) << FRAC_BITS;
	localparam logic [14:0] UNIT_ONE     = 15'(1) << UNIT_FRAC;

	localparam logic [1:0] SEL_START = 2'd0;
	localparam logic [1:0] SEL_END   = 2'd1;
	localparam logic [1:0] SEL_MID   = 2'd2;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic        [30:0] seg_length;
	} query_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
		logic signed [15:0] push_x;
		logic signed [15:0] push_y;
		logic signed [31:0] depth;
	} result_t;

	// carried through the square root stages
	typedef struct packed {
		logic               rej;
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
		logic               neg_x;
		logic               neg_y;
		logic        [30:0] adx;
		logic        [30:0] ady;
		logic        [2:0]  k;
	} sq_ctl_t;

	// carried through the divide stages
	typedef struct packed {
		logic               rej;
		logic               zero;
		logic               hit;
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
		logic               neg_x;
		logic               neg_y;
		logic signed [31:0] depth;
	} dv_ctl_t;

	function automatic logic signed [31:0] sat_coord(input logic signed [37:0] v);
		logic signed [37:0] hi;
		logic signed [37:0] lo;
		hi = 38'sd2147483647;
		lo = -38'sd2147483648;
		if (v > hi)
			return 32'sh7fffffff;
		else if (v < lo)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic [2:0] norm_shift(input logic [35:0] m);
		if (m[35])
			return 3'd5;
		else if (m[34])
			return 3'd4;
		else if (m[33])
			return 3'd3;
		else if (m[32])
			return 3'd2;
		else if (m[31])
			return 3'd1;
		else
			return 3'd0;
	endfunction

endpackage

FILE: hw/rtl/circle_segment_contact_unit.sv
// Circle against directed segment contact, fully pipelined.
// Throughput: one query per cycle, busy is never raised.
// The 32-step root and the 15-step normal divide set most of the pipeline depth
// between the start beat and the done pulse.
// Reset: asynchronous, clears the pipeline valid bits and sets the radius to 1.0.
// The receiver cannot stall; every result is shown for exactly one cycle.
module circle_segment_contact_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  csc_pkg::query_t      query,
	output logic                 done,
	output csc_pkg::result_t     result,
	input  logic                 cfg_we,
	input  logic [30:0]          cfg_wdata
);
	import csc_pkg::*;

	logic [30:0] radius_q;

	// stage 1
	logic               v_s1;
	logic signed [48:0] pnx_s1, pny_s1, pux_s1, puy_s1;
	logic signed [31:0] cx_s1, cy_s1, sx_s1, sy_s1, ex_s1, ey_s1;
	logic signed [15:0] ux_s1, uy_s1;
	logic        [30:0] len_s1;
	// stage 2
	logic               v_s2, rej_s2;
	logic        [1:0]  sel_s2;
	logic        [30:0] x_s2;
	logic signed [31:0] cx_s2, cy_s2, sx_s2, sy_s2, ex_s2, ey_s2;
	logic signed [15:0] ux_s2, uy_s2;
	// stage 3
	logic               v_s3, rej_s3;
	logic        [1:0]  sel_s3;
	logic signed [48:0] tx_s3, ty_s3;
	logic signed [31:0] cx_s3, cy_s3, sx_s3, sy_s3, ex_s3, ey_s3;
	// stage 4
	logic               v_s4, rej_s4;
	logic signed [35:0] px_s4, py_s4;
	logic signed [31:0] cx_s4, cy_s4;
	// stage 5
	logic               v_s5, rej_s5;
	logic signed [35:0] dx_s5, dy_s5;
	logic signed [31:0] qx_s5, qy_s5;
	// stage 6
	logic               v_s6;
	sq_ctl_t            c_s6;
	// stage 7
	logic               v_s7;
	sq_ctl_t            c_s7;
	logic        [61:0] sqx_s7, sqy_s7;

	// root stages, index 0 is stage 8
	logic               sq_v_s   [0:SQRT_STEPS];
	sq_ctl_t            sq_c_s   [0:SQRT_STEPS];
	logic        [63:0] sq_rem_s [0:SQRT_STEPS];
	logic        [63:0] sq_res_s [0:SQRT_STEPS];
	logic        [63:0] sq_rem_n [1:SQRT_STEPS];
	logic        [63:0] sq_res_n [1:SQRT_STEPS];

	// divide stages, index 0 is the stage after the root
	logic               dv_v_s   [0:DIV_STEPS];
	dv_ctl_t            dv_c_s   [0:DIV_STEPS];
	logic        [31:0] dv_root_s[0:DIV_STEPS];
	logic        [46:0] dv_rx_s  [0:DIV_STEPS];
	logic        [46:0] dv_ry_s  [0:DIV_STEPS];
	logic        [14:0] dv_qx_s  [0:DIV_STEPS];
	logic        [14:0] dv_qy_s  [0:DIV_STEPS];
	logic        [46:0] dv_rx_n  [1:DIV_STEPS];
	logic        [46:0] dv_ry_n  [1:DIV_STEPS];
	logic        [14:0] dv_qx_n  [1:DIV_STEPS];
	logic        [14:0] dv_qy_n  [1:DIV_STEPS];

	logic    done_q;
	result_t result_q;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// stage 1 logic
	logic signed [32:0] ax, ay;
	assign ax = 33'(query.center_x) - 33'(query.start_x);
	assign ay = 33'(query.center_y) - 33'(query.start_y);

	// stage 2 logic
	logic signed [49:0] ndot, xdot, rlim, llim;
	assign ndot = 50'(pnx_s1) + 50'(pny_s1);
	assign xdot = 50'(pux_s1) + 50'(puy_s1);
	assign rlim = $signed({5'b0, radius_q, 14'b0});
	assign llim = $signed({5'b0, len_s1, 14'b0});

	// stage 4 logic
	logic signed [35:0] px_n, py_n;
	always_comb begin
		case (sel_s3)
			SEL_START: begin
				px_n = 36'(sx_s3);
				py_n = 36'(sy_s3);
			end
			SEL_END: begin
				px_n = 36'(ex_s3);
				py_n = 36'(ey_s3);
			end
			default: begin
				px_n = 36'(sx_s3) + 36'(tx_s3 >>> UNIT_FRAC);
				py_n = 36'(sy_s3) + 36'(ty_s3 >>> UNIT_FRAC);
			end
		endcase
	end

	// stage 6 logic
	logic [35:0] adx_f, ady_f, m_f;
	logic [2:0]  k_f;
	always_comb begin
		adx_f = dx_s5[35] ? 36'(-dx_s5) : 36'(dx_s5);
		ady_f = dy_s5[35] ? 36'(-dy_s5) : 36'(dy_s5);
		m_f   = (adx_f > ady_f) ? adx_f : ady_f;
		k_f   = norm_shift(m_f);
	end

	// root steps
	always_comb begin
		for (int i = 0; i < SQRT_STEPS; i++) begin
			logic [63:0] bitv;
			logic [63:0] trial;
			bitv  = 64'd1 << (2 * (SQRT_STEPS - 1 - i));
			trial = sq_res_s[i] + bitv;
			if (sq_rem_s[i] >= trial) begin
				sq_rem_n[i+1] = sq_rem_s[i] - trial;
				sq_res_n[i+1] = (sq_res_s[i] >> 1) + bitv;
			end else begin
				sq_rem_n[i+1] = sq_rem_s[i];
				sq_res_n[i+1] = sq_res_s[i] >> 1;
			end
		end
	end

	// after root
	logic        [31:0] root;
	logic        [36:0] mag;
	logic signed [37:0] dep;
	assign root = sq_res_s[SQRT_STEPS][31:0];
	assign mag  = 37'(root) << sq_c_s[SQRT_STEPS].k;
	assign dep  = $signed({7'b0, radius_q}) - $signed({1'b0, mag});

	// divide steps
	always_comb begin
		for (int j = 0; j < DIV_STEPS; j++) begin
			logic [46:0] dsub;
			dsub = 47'(dv_root_s[j]) << (DIV_STEPS - 1 - j);
			dv_qx_n[j+1] = dv_qx_s[j];
			dv_qy_n[j+1] = dv_qy_s[j];
			if (dv_rx_s[j] >= dsub) begin
				dv_rx_n[j+1] = dv_rx_s[j] - dsub;
				dv_qx_n[j+1][DIV_STEPS-1-j] = 1'b1;
			end else begin
				dv_rx_n[j+1] = dv_rx_s[j];
			end
			if (dv_ry_s[j] >= dsub) begin
				dv_ry_n[j+1] = dv_ry_s[j] - dsub;
				dv_qy_n[j+1][DIV_STEPS-1-j] = 1'b1;
			end else begin
				dv_ry_n[j+1] = dv_ry_s[j];
			end
		end
	end

	// output shaping
	dv_ctl_t            fc;
	logic        [14:0] qx_c, qy_c;
	logic signed [15:0] pushx_f, pushy_f;
	result_t            res_n;
	always_comb begin
		fc      = dv_c_s[DIV_STEPS];
		qx_c    = (dv_qx_s[DIV_STEPS] > UNIT_ONE) ? UNIT_ONE : dv_qx_s[DIV_STEPS];
		qy_c    = (dv_qy_s[DIV_STEPS] > UNIT_ONE) ? UNIT_ONE : dv_qy_s[DIV_STEPS];
		pushx_f = fc.neg_x ? -$signed({1'b0, qx_c}) : $signed({1'b0, qx_c});
		pushy_f = fc.neg_y ? -$signed({1'b0, qy_c}) : $signed({1'b0, qy_c});
		if (fc.zero) begin
			pushx_f = '0;
			pushy_f = '0;
		end
		res_n.hit       = fc.hit;
		res_n.contact_x = fc.contact_x;
		res_n.contact_y = fc.contact_y;
		res_n.push_x    = pushx_f;
		res_n.push_y    = pushy_f;
		res_n.depth     = fc.depth;
		if (fc.rej)
			res_n = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			for (int i = 0; i <= SQRT_STEPS; i++)
				sq_v_s[i] <= 1'b0;
			for (int j = 0; j <= DIV_STEPS; j++)
				dv_v_s[j] <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we)
				radius_q <= cfg_wdata;
			v_s1      <= accept;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			sq_v_s[0] <= v_s7;
			for (int i = 0; i < SQRT_STEPS; i++)
				sq_v_s[i+1] <= sq_v_s[i];
			dv_v_s[0] <= sq_v_s[SQRT_STEPS];
			for (int j = 0; j < DIV_STEPS; j++)
				dv_v_s[j+1] <= dv_v_s[j];
			done_q    <= dv_v_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		// stage 1
		pnx_s1 <= ax * query.normal_x;
		pny_s1 <= ay * query.normal_y;
		pux_s1 <= ax * query.dir_x;
		puy_s1 <= ay * query.dir_y;
		cx_s1  <= query.center_x;
		cy_s1  <= query.center_y;
		sx_s1  <= query.start_x;
		sy_s1  <= query.start_y;
		ex_s1  <= query.end_x;
		ey_s1  <= query.end_y;
		ux_s1  <= query.dir_x;
		uy_s1  <= query.dir_y;
		len_s1 <= query.seg_length;
		// stage 2
		rej_s2 <= (ndot < -rlim) || (ndot > rlim);
		if (xdot < 0)
			sel_s2 <= SEL_START;
		else if (xdot > llim)
			sel_s2 <= SEL_END;
		else
			sel_s2 <= SEL_MID;
		x_s2  <= xdot[44:14];
		cx_s2 <= cx_s1;
		cy_s2 <= cy_s1;
		sx_s2 <= sx_s1;
		sy_s2 <= sy_s1;
		ex_s2 <= ex_s1;
		ey_s2 <= ey_s1;
		ux_s2 <= ux_s1;
		uy_s2 <= uy_s1;
		// stage 3
		rej_s3 <= rej_s2;
		sel_s3 <= sel_s2;
		tx_s3  <= ux_s2 * $signed({1'b0, x_s2}) + 49'sd8192;
		ty_s3  <= uy_s2 * $signed({1'b0, x_s2}) + 49'sd8192;
		cx_s3  <= cx_s2;
		cy_s3  <= cy_s2;
		sx_s3  <= sx_s2;
		sy_s3  <= sy_s2;
		ex_s3  <= ex_s2;
		ey_s3  <= ey_s2;
		// stage 4
		rej_s4 <= rej_s3;
		px_s4  <= px_n;
		py_s4  <= py_n;
		cx_s4  <= cx_s3;
		cy_s4  <= cy_s3;
		// stage 5
		rej_s5 <= rej_s4;
		dx_s5  <= 36'(cx_s4) - px_s4;
		dy_s5  <= 36'(cy_s4) - py_s4;
		qx_s5  <= sat_coord(38'(px_s4));
		qy_s5  <= sat_coord(38'(py_s4));
		// stage 6
		c_s6.rej       <= rej_s5;
		c_s6.contact_x <= qx_s5;
		c_s6.contact_y <= qy_s5;
		c_s6.neg_x     <= dx_s5[35];
		c_s6.neg_y     <= dy_s5[35];
		c_s6.adx       <= 31'(adx_f >> k_f);
		c_s6.ady       <= 31'(ady_f >> k_f);
		c_s6.k         <= k_f;
		// stage 7
		c_s7   <= c_s6;
		sqx_s7 <= c_s6.adx * c_s6.adx;
		sqy_s7 <= c_s6.ady * c_s6.ady;
		// root
		sq_c_s[0]   <= c_s7;
		sq_rem_s[0] <= 64'(sqx_s7) + 64'(sqy_s7);
		sq_res_s[0] <= '0;
		for (int i = 0; i < SQRT_STEPS; i++) begin
			sq_c_s[i+1]   <= sq_c_s[i];
			sq_rem_s[i+1] <= sq_rem_n[i+1];
			sq_res_s[i+1] <= sq_res_n[i+1];
		end
		// divide setup
		dv_c_s[0].rej       <= sq_c_s[SQRT_STEPS].rej;
		dv_c_s[0].zero      <= (root == '0);
		dv_c_s[0].hit       <= (dep > 0);
		dv_c_s[0].contact_x <= sq_c_s[SQRT_STEPS].contact_x;
		dv_c_s[0].contact_y <= sq_c_s[SQRT_STEPS].contact_y;
		dv_c_s[0].neg_x     <= sq_c_s[SQRT_STEPS].neg_x;
		dv_c_s[0].neg_y     <= sq_c_s[SQRT_STEPS].neg_y;
		dv_c_s[0].depth     <= sat_coord(dep);
		dv_root_s[0]        <= root;
		dv_rx_s[0]          <= {2'b0, sq_c_s[SQRT_STEPS].adx, 14'b0} + 47'(root[31:1]);
		dv_ry_s[0]          <= {2'b0, sq_c_s[SQRT_STEPS].ady, 14'b0} + 47'(root[31:1]);
		dv_qx_s[0]          <= '0;
		dv_qy_s[0]          <= '0;
		for (int j = 0; j < DIV_STEPS; j++) begin
			dv_c_s[j+1]    <= dv_c_s[j];
			dv_root_s[j+1] <= dv_root_s[j];
			dv_rx_s[j+1]   <= dv_rx_n[j+1];
			dv_ry_s[j+1]   <= dv_ry_n[j+1];
			dv_qx_s[j+1]   <= dv_qx_n[j+1];
			dv_qy_s[j+1]   <= dv_qy_n[j+1];
		end
		result_q <= res_n;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
